// ----- sv/bc1_pkg.sv -----
// shared types, constants and arithmetic helpers of the bc1 block decoder
package bc1_pkg;

    localparam int MAX_IMAGE_SIDE_DEF = 4096;
    localparam int CFG_W              = 13;
    localparam int SIZE_RESET         = 4;

    localparam logic [15:0] RED_FIELD   = 16'hF800;
    localparam logic [15:0] GREEN_FIELD = 16'h07E0;
    localparam logic [15:0] BLUE_FIELD  = 16'h001F;
    localparam logic [1:0]  CODE_MASK   = 2'h3;

    typedef enum logic [0:0] {
        CFG_IMAGE_WIDTH  = 1'b0,
        CFG_IMAGE_HEIGHT = 1'b1
    } t_cfg_index;

    typedef struct packed {
        logic [15:0] endpoint_a;
        logic [15:0] endpoint_b;
        logic [31:0] index_word;
    } t_in;

    typedef struct packed {
        logic [11:0] pixel_x;
        logic [11:0] pixel_y;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic        inside_res;
        logic        last;
    } t_out;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } t_rgb;

    typedef t_rgb [3:0] t_palette;

    // n / 3 for n below 768 by reciprocal multiply
    function automatic logic [7:0] div3(input logic [9:0] n);
        logic [20:0] prod;
        prod = 21'(n) * 21'd683;
        return prod[18:11];
    endfunction

endpackage

// ----- sv/bc1_palette.sv -----
// endpoint widening and four-entry palette generation for one block
module bc1_palette (
    input  logic [15:0]        i_endpoint_a,
    input  logic [15:0]        i_endpoint_b,
    output bc1_pkg::t_palette  o_palette
);

    bc1_pkg::t_rgb ca;
    bc1_pkg::t_rgb cb;
    logic          four;

    function automatic bc1_pkg::t_rgb widen(input logic [15:0] c);
        bc1_pkg::t_rgb v;
        logic [15:0]   rr;
        logic [15:0]   gg;
        logic [15:0]   bb;
        rr  = c & bc1_pkg::RED_FIELD;
        gg  = c & bc1_pkg::GREEN_FIELD;
        bb  = c & bc1_pkg::BLUE_FIELD;
        v.r = {rr[15:11], 3'b000};
        v.g = {gg[10:5], 2'b00};
        v.b = {bb[4:0], 3'b000};
        return v;
    endfunction

    function automatic logic [7:0] third(input logic [7:0] p, input logic [7:0] q);
        logic [9:0] s;
        s = 10'({p, 1'b0}) + 10'(q);
        return bc1_pkg::div3(s);
    endfunction

    function automatic logic [7:0] half(input logic [7:0] p, input logic [7:0] q);
        logic [8:0] s;
        s = 9'(p) + 9'(q);
        return s[8:1];
    endfunction

    assign ca   = widen(i_endpoint_a);
    assign cb   = widen(i_endpoint_b);
    assign four = i_endpoint_a > i_endpoint_b;

    always_comb begin
        o_palette[0] = ca;
        o_palette[1] = cb;
        if (four) begin
            o_palette[2].r = third(ca.r, cb.r);
            o_palette[2].g = third(ca.g, cb.g);
            o_palette[2].b = third(ca.b, cb.b);
            o_palette[3].r = third(cb.r, ca.r);
            o_palette[3].g = third(cb.g, ca.g);
            o_palette[3].b = third(cb.b, ca.b);
        end else begin
            o_palette[2].r = half(ca.r, cb.r);
            o_palette[2].g = half(ca.g, cb.g);
            o_palette[2].b = half(ca.b, cb.b);
            o_palette[3]   = '0;
        end
    end

endmodule

// ----- sv/bc1_block_walk.sv -----
// image size registers and block position counters
module bc1_block_walk #(
    parameter int MAX_IMAGE_SIDE = bc1_pkg::MAX_IMAGE_SIDE_DEF,
    parameter int CW             = ((MAX_IMAGE_SIDE + 3) / 4 > 1)
                                   ? $clog2((MAX_IMAGE_SIDE + 3) / 4) : 1,
    parameter int SW             = $clog2(MAX_IMAGE_SIDE + 1)
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  bc1_pkg::t_cfg_index       i_cfg_index,
    input  logic [bc1_pkg::CFG_W-1:0] i_cfg_data,
    input  logic                      i_advance,
    output logic [CW-1:0]             o_col,
    output logic [CW-1:0]             o_row,
    output logic [SW-1:0]             o_width,
    output logic [SW-1:0]             o_height
);

    logic [bc1_pkg::CFG_W-1:0] r_width;
    logic [bc1_pkg::CFG_W-1:0] r_height;
    logic [CW-1:0]             r_col;
    logic [CW-1:0]             r_row;
    logic [CW-1:0]             n_col;
    logic [CW-1:0]             n_row;
    logic [31:0]               blocks_x;
    logic [31:0]               blocks_y;
    logic [31:0]               col_inc;
    logic [31:0]               row_inc;

    function automatic logic [SW-1:0] eff_side(input logic [bc1_pkg::CFG_W-1:0] v);
        logic [31:0] v32;
        v32 = 32'(v);
        if (v32 == 32'd0) begin
            return SW'(1);
        end else if (v32 > 32'(MAX_IMAGE_SIDE)) begin
            return SW'(MAX_IMAGE_SIDE);
        end
        return SW'(v32);
    endfunction

    assign o_width  = eff_side(r_width);
    assign o_height = eff_side(r_height);
    assign blocks_x = (32'(o_width) + 32'd3) >> 2;
    assign blocks_y = (32'(o_height) + 32'd3) >> 2;
    assign col_inc  = 32'(r_col) + 32'd1;
    assign row_inc  = 32'(r_row) + 32'd1;
    assign o_col    = r_col;
    assign o_row    = r_row;

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (i_advance) begin
            if (col_inc >= blocks_x) begin
                n_col = '0;
                n_row = (row_inc >= blocks_y) ? '0 : CW'(row_inc);
            end else begin
                n_col = CW'(col_inc);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= bc1_pkg::CFG_W'(bc1_pkg::SIZE_RESET);
            r_height <= bc1_pkg::CFG_W'(bc1_pkg::SIZE_RESET);
            r_col    <= '0;
            r_row    <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    bc1_pkg::CFG_IMAGE_WIDTH:  r_width  <= i_cfg_data;
                    bc1_pkg::CFG_IMAGE_HEIGHT: r_height <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

endmodule

// ----- sv/bc1_block_decoder_unit.sv -----
// top level of the bc1 block decoder: block register, pixel sequencer, output register
//
// input channel i_in_valid / o_in_stall carries one 64-bit color block per transaction
// (two rgb565 endpoints and sixteen 2-bit indices). output channel o_out_valid /
// i_out_stall carries one decoded pixel per transaction, sixteen per block in raster
// order within the block, with last set on the sixteenth.
// the palette is built as the block is taken and held in the block register; the
// sequencer then picks one pixel per cycle into the output register while the output
// does not stall. each pixel passes from the block register through the output
// register. the single pixel lane behind the block register handles one pixel at a
// time; the next block is taken in the cycle its predecessor's last pixel moves to
// the output register, so blocks stream without gaps.
// configuration: i_cfg_we writes image_width (index 0) or image_height (index 1);
// write only while no pixel is outstanding. block positions walk left to right, top
// to bottom, and wrap after the last block.
// reset clears both valid flags, the pixel counter and the block position, and sets
// the size to 4 by 4. a stall on the output holds the pixel and, once the block
// register is busy, stalls the input.
module bc1_block_decoder_unit #(
    parameter int MAX_IMAGE_SIDE = bc1_pkg::MAX_IMAGE_SIDE_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  bc1_pkg::t_cfg_index       i_cfg_index,
    input  logic [bc1_pkg::CFG_W-1:0] i_cfg_data,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  bc1_pkg::t_in              i_in,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output bc1_pkg::t_out             o_out
);

    localparam int CW = ((MAX_IMAGE_SIDE + 3) / 4 > 1) ? $clog2((MAX_IMAGE_SIDE + 3) / 4) : 1;
    localparam int SW = $clog2(MAX_IMAGE_SIDE + 1);
    localparam int XW = CW + 2;

    logic [CW-1:0]     blk_col;
    logic [CW-1:0]     blk_row;
    logic [SW-1:0]     width;
    logic [SW-1:0]     height;
    bc1_pkg::t_palette palette;
    logic              in_acc;
    logic              out_adv;
    logic              pix_go;
    logic              blk_done;
    logic [1:0]        code;
    logic [XW-1:0]     pix_x;
    logic [XW-1:0]     pix_y;

    logic              r_blk_valid;
    bc1_pkg::t_palette r_pal;
    logic [31:0]       r_idx;
    logic [CW-1:0]     r_col;
    logic [CW-1:0]     r_row;
    logic [3:0]        r_k;
    logic              r_out_valid;
    bc1_pkg::t_out     r_out;
    bc1_pkg::t_out     n_out;

    bc1_block_walk #(
        .MAX_IMAGE_SIDE (MAX_IMAGE_SIDE),
        .CW             (CW),
        .SW             (SW)
    ) u_walk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_advance   (in_acc),
        .o_col       (blk_col),
        .o_row       (blk_row),
        .o_width     (width),
        .o_height    (height)
    );

    bc1_palette u_palette (
        .i_endpoint_a (i_in.endpoint_a),
        .i_endpoint_b (i_in.endpoint_b),
        .o_palette    (palette)
    );

    assign out_adv    = !r_out_valid || !i_out_stall;
    assign pix_go     = r_blk_valid && out_adv;
    assign blk_done   = pix_go && (r_k == 4'd15);
    assign o_in_stall = r_blk_valid && !blk_done;
    assign in_acc     = i_in_valid && !o_in_stall;

    assign code  = r_idx[1:0] & bc1_pkg::CODE_MASK;
    assign pix_x = {r_col, r_k[1:0]};
    assign pix_y = {r_row, r_k[3:2]};

    always_comb begin
        n_out.pixel_x    = 12'(pix_x);
        n_out.pixel_y    = 12'(pix_y);
        n_out.red        = r_pal[code].r;
        n_out.green      = r_pal[code].g;
        n_out.blue       = r_pal[code].b;
        n_out.inside_res = (32'(pix_x) < 32'(width)) && (32'(pix_y) < 32'(height));
        n_out.last       = (r_k == 4'd15);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blk_valid <= 1'b0;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_blk_valid <= 1'b1;
                r_k         <= '0;
                r_pal       <= palette;
                r_idx       <= i_in.index_word;
                r_col       <= blk_col;
                r_row       <= blk_row;
            end else if (pix_go) begin
                r_blk_valid <= !blk_done;
                r_k         <= r_k + 4'd1;
                r_idx       <= r_idx >> 2;
            end
            if (out_adv) begin
                r_out_valid <= pix_go;
                if (pix_go) begin
                    r_out <= n_out;
                end
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // last pixel sits in the bottom right corner of its block
    a_last_corner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.last |-> (o_out.pixel_x[1:0] == 2'b11)
                                   && (o_out.pixel_y[1:0] == 2'b11))
        else $error("last pixel not at block corner");

    // a new block only enters when the block register is empty or the previous block's last pixel moves on
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |-> !r_blk_valid || (r_k == 4'd15 && out_adv))
        else $error("block register overwritten");

    // a taken block starts at pixel zero
    a_start_k0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_blk_valid && (r_k == 4'd0))
        else $error("block did not start at first pixel");

endmodule
